/* hw/rtl/keyframe_animation_sequencer_core_macros.svh */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer assertion macros
// Short forms for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_ANIMATION_SEQUENCER_CORE_MACROS_SVH
`define KEYFRAME_ANIMATION_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication on clk, off while rst_n is low
`define KAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, off while rst_n is low
`define KAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/kas_pkg.sv */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer package
// Widths, operation codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package kas_pkg;

    // Sizing
    localparam int MAX_FRAMES = 256;
    localparam int BLEND_BITS = 16;
    localparam int TIME_W     = 16;
    localparam int CYC_W      = 16;
    localparam int COUNT_W    = 9;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int END_W      = TIME_W + FRAME_W;
    localparam int ELAPSED_W  = END_W + 1;
    localparam int NUM_W      = END_W + FRAME_W;
    localparam int DIV_W      = NUM_W + BLEND_BITS;
    localparam int ITER_W     = $clog2(DIV_W);
    localparam int Q_W        = (ELAPSED_W > FRAME_W + BLEND_BITS) ?
                                ELAPSED_W : FRAME_W + BLEND_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA   = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ADVANCE = 2'd0,
        OP_START   = 2'd1,
        OP_PAUSE   = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CHECK,
        ST_WRAP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/kas_item_if.sv */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface kas_item_if
    import kas_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [TIME_W-1:0]   delta_time;
    logic [TIME_W-1:0]   frame_period;
    logic                loop_mode;
    logic                pause_flag;

    modport source (
        output valid, operation, delta_time, frame_period, loop_mode, pause_flag,
        input  ready
    );
    modport sink (
        input  valid, operation, delta_time, frame_period, loop_mode, pause_flag,
        output ready
    );
endinterface

/* hw/rtl/kas_result_if.sv */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer result channel
// Valid/ready channel carrying one status item per command.
// ----------------------------------------------------------------------------
interface kas_result_if
    import kas_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [FRAME_W-1:0]    base_frame;
    logic [FRAME_W-1:0]    next_frame;
    logic [BLEND_BITS-1:0] blend;
    logic                  active;
    logic                  paused;
    logic                  finished;
    logic [CYC_W-1:0]      cycle_count;
    logic                  start_ok;
    logic                  frame_changed;

    modport source (
        output valid, base_frame, next_frame, blend, active, paused, finished,
               cycle_count, start_ok, frame_changed,
        input  ready
    );
    modport sink (
        input  valid, base_frame, next_frame, blend, active, paused, finished,
               cycle_count, start_ok, frame_changed,
        output ready
    );
endinterface

/* hw/rtl/kas_cfg_if.sv */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer configuration channel
// Valid/ready register write channel: index and data.
// ----------------------------------------------------------------------------
interface kas_cfg_if
    import kas_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* hw/rtl/keyframe_animation_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Keyframe animation sequencer core
// Flow: start, pause and ignored items go from EXEC straight to DONE; an advance
// that places frames goes through CHECK, MUL and DIV, plus WRAP on a looping wrap.
// Throughput: one item at a time; the shared restoring divider (one quotient
// bit per cycle, 48 bits for frame and blend, 25 for wraps) sets the rate.
// Reset: asynchronous, active low; clears run state, count 1, min delta 7.
// ----------------------------------------------------------------------------
`include "keyframe_animation_sequencer_core_macros.svh"

module keyframe_animation_sequencer_core
    import kas_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    kas_item_if.sink      item,
    kas_result_if.source  result,
    kas_cfg_if.sink       cfg
);

    typedef struct packed {
        logic [FRAME_W-1:0]    base_frame;
        logic [FRAME_W-1:0]    next_frame;
        logic [BLEND_BITS-1:0] blend;
        logic                  active;
        logic                  paused;
        logic                  finished;
        logic [CYC_W-1:0]      cycle_count;
        logic                  start_ok;
        logic                  frame_changed;
    } res_t;

    // Sequencer and configuration
    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     frame_count_reg, frame_count_next;
    logic [TIME_W-1:0]      min_delta_reg, min_delta_next;

    // Latched item
    op_t                    op_reg, op_next;
    logic [TIME_W-1:0]      delta_reg, delta_next;
    logic [TIME_W-1:0]      period_reg, period_next;
    logic                   loop_in_reg, loop_in_next;
    logic                   pflag_reg, pflag_next;
    logic [FRAME_W-1:0]     before_reg, before_next;
    logic                   ok_reg, ok_next;

    // Playback state
    logic [ELAPSED_W-1:0]   elapsed_reg, elapsed_next;
    logic [END_W-1:0]       end_time_reg, end_time_next;
    logic [CYC_W-1:0]       cycles_reg, cycles_next;
    logic [FRAME_W-1:0]     cur_frame_reg, cur_frame_next;
    logic [FRAME_W-1:0]     nxt_frame_reg, nxt_frame_next;
    logic [BLEND_BITS-1:0]  blend_reg, blend_next;
    logic                   active_reg, active_next;
    logic                   loop_reg, loop_next;
    logic                   paused_reg, paused_next;

    // Shared divider
    logic [DIV_W-1:0]       dvd_reg, dvd_next;
    logic [END_W-1:0]       rem_reg, rem_next;
    logic [Q_W-1:0]         quo_reg, quo_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;

    // Result register
    res_t                   res_reg, res_next;
    logic                   res_valid_reg, res_valid_next;

    // Combinational helpers
    logic [COUNT_W-1:0]     cnt_eff;
    logic [FRAME_W-1:0]     last_frame;
    logic [TIME_W-1:0]      period_eff;
    logic [ELAPSED_W-1:0]   trial;
    logic                   fits;
    logic [END_W-1:0]       rem_step;
    logic [Q_W-1:0]         quo_step;
    logic [NUM_W-1:0]       num_prod;
    logic [COUNT_W-1:0]     base_inc;
    logic [ELAPSED_W:0]     cyc_sum;
    logic [CYC_W:0]         cyc_inc;
    logic [FRAME_W-1:0]     q_base;

    // Effective frame count and derived values
    always_comb
    begin
        if (frame_count_reg == '0)
            cnt_eff = COUNT_W'(1);
        else if (frame_count_reg > COUNT_W'(MAX_FRAMES))
            cnt_eff = COUNT_W'(MAX_FRAMES);
        else
            cnt_eff = frame_count_reg;
        last_frame = FRAME_W'(cnt_eff - COUNT_W'(1));
        period_eff = (period_reg == '0) ? TIME_W'(1) : period_reg;
    end

    // One restoring division step against end_time
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits     = (trial >= {1'b0, end_time_reg});
    assign rem_step = fits ? END_W'(trial - {1'b0, end_time_reg}) : trial[END_W-1:0];
    assign quo_step = {quo_reg[Q_W-2:0], fits};

    // Frame numerator; elapsed never exceeds end_time here
    assign num_prod = NUM_W'(elapsed_reg[END_W-1:0] * last_frame);

    // Frame index from the final quotient and its successor
    assign q_base   = quo_step[FRAME_W+BLEND_BITS-1:BLEND_BITS];
    assign base_inc = COUNT_W'(q_base) + COUNT_W'(1);

    // Saturating cycle count updates
    assign cyc_sum  = (ELAPSED_W+1)'(cycles_reg) + (ELAPSED_W+1)'(quo_step[ELAPSED_W-1:0]);
    assign cyc_inc  = (CYC_W+1)'(cycles_reg) + (CYC_W+1)'(1);

    // Handshake outputs
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid         = res_valid_reg;
    assign result.base_frame    = res_reg.base_frame;
    assign result.next_frame    = res_reg.next_frame;
    assign result.blend         = res_reg.blend;
    assign result.active        = res_reg.active;
    assign result.paused        = res_reg.paused;
    assign result.finished      = res_reg.finished;
    assign result.cycle_count   = res_reg.cycle_count;
    assign result.start_ok      = res_reg.start_ok;
    assign result.frame_changed = res_reg.frame_changed;

    // Next state and datapath
    always_comb
    begin
        state_next       = state_reg;
        frame_count_next = frame_count_reg;
        min_delta_next   = min_delta_reg;
        op_next          = op_reg;
        delta_next       = delta_reg;
        period_next      = period_reg;
        loop_in_next     = loop_in_reg;
        pflag_next       = pflag_reg;
        before_next      = before_reg;
        ok_next          = ok_reg;
        elapsed_next     = elapsed_reg;
        end_time_next    = end_time_reg;
        cycles_next      = cycles_reg;
        cur_frame_next   = cur_frame_reg;
        nxt_frame_next   = nxt_frame_reg;
        blend_next       = blend_reg;
        active_next      = active_reg;
        loop_next        = loop_reg;
        paused_next      = paused_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        iter_next        = iter_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg;

        // Drop the result once taken
        if (res_valid_reg && result.ready)
            res_valid_next = 1'b0;

        // Register writes
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_COUNT: frame_count_next = cfg.data[COUNT_W-1:0];
                REG_MIN_DELTA:   min_delta_next   = cfg.data[TIME_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            // Latch the item
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    op_next      = op_t'(item.operation);
                    delta_next   = item.delta_time;
                    period_next  = item.frame_period;
                    loop_in_next = item.loop_mode;
                    pflag_next   = item.pause_flag;
                    before_next  = cur_frame_reg;
                    state_next   = ST_EXEC;
                end
            end

            // Decode the operation
            ST_EXEC:
            begin
                ok_next    = 1'b0;
                state_next = ST_DONE;
                case (op_reg)
                    OP_START:
                    begin
                        if (cnt_eff > COUNT_W'(1))
                        begin
                            end_time_next  = END_W'(period_eff * cnt_eff);
                            elapsed_next   = '0;
                            cycles_next    = '0;
                            cur_frame_next = '0;
                            nxt_frame_next = FRAME_W'(1);
                            blend_next     = '0;
                            active_next    = 1'b1;
                            loop_next      = loop_in_reg;
                            paused_next    = 1'b0;
                            ok_next        = 1'b1;
                        end
                    end
                    OP_PAUSE:
                    begin
                        if (active_reg)
                            paused_next = pflag_reg;
                    end
                    OP_ADVANCE:
                    begin
                        if (active_reg && !paused_reg && (delta_reg >= min_delta_reg)
                            && (end_time_reg != '0))
                        begin
                            elapsed_next = elapsed_reg + ELAPSED_W'(delta_reg);
                            state_next   = ST_CHECK;
                        end
                    end
                    default: ;
                endcase
            end

            // Handle overrun: clamp and stop, or start the wrap division; else go to MUL
            ST_CHECK:
            begin
                if (elapsed_reg > {1'b0, end_time_reg})
                begin
                    if (!loop_reg)
                    begin
                        elapsed_next   = {1'b0, end_time_reg};
                        cycles_next    = cyc_inc[CYC_W] ? {CYC_W{1'b1}} : cyc_inc[CYC_W-1:0];
                        cur_frame_next = last_frame;
                        nxt_frame_next = last_frame;
                        blend_next     = '0;
                        active_next    = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        dvd_next   = {elapsed_reg, {(DIV_W-ELAPSED_W){1'b0}}};
                        rem_next   = '0;
                        iter_next  = '0;
                        state_next = ST_WRAP;
                    end
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            // Wraps and remainder of elapsed over end_time
            ST_WRAP:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[DIV_W-2:0], 1'b0};
                quo_next  = quo_step;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(ELAPSED_W-1))
                begin
                    elapsed_next = {1'b0, rem_step};
                    if (cyc_sum > (ELAPSED_W+1)'({CYC_W{1'b1}}))
                        cycles_next = {CYC_W{1'b1}};
                    else
                        cycles_next = cyc_sum[CYC_W-1:0];
                    state_next = ST_MUL;
                end
            end

            // Load frame numerator followed by the blend fraction bits
            ST_MUL:
            begin
                dvd_next   = {num_prod, {BLEND_BITS{1'b0}}};
                rem_next   = '0;
                iter_next  = '0;
                state_next = ST_DIV;
            end

            // Frame index and blend in one long division
            ST_DIV:
            begin
                rem_next  = rem_step;
                dvd_next  = {dvd_reg[DIV_W-2:0], 1'b0};
                quo_next  = quo_step;
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_W'(DIV_W-1))
                begin
                    cur_frame_next = q_base;
                    nxt_frame_next = (base_inc == cnt_eff) ? '0 : base_inc[FRAME_W-1:0];
                    blend_next     = quo_step[BLEND_BITS-1:0];
                    state_next     = ST_DONE;
                end
            end

            // Hand the result to the output register
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_next.base_frame    = cur_frame_reg;
                    res_next.next_frame    = nxt_frame_reg;
                    res_next.blend         = blend_reg;
                    res_next.active        = active_reg;
                    res_next.paused        = paused_reg;
                    res_next.finished      = !active_reg && (cycles_reg != '0);
                    res_next.cycle_count   = cycles_reg;
                    res_next.start_ok      = ok_reg;
                    res_next.frame_changed = (cur_frame_reg != before_reg);
                    res_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= COUNT_W'(1);
            min_delta_reg   <= TIME_W'(7);
            op_reg          <= OP_ADVANCE;
            delta_reg       <= '0;
            period_reg      <= '0;
            loop_in_reg     <= 1'b0;
            pflag_reg       <= 1'b0;
            before_reg      <= '0;
            ok_reg          <= 1'b0;
            elapsed_reg     <= '0;
            end_time_reg    <= '0;
            cycles_reg      <= '0;
            cur_frame_reg   <= '0;
            nxt_frame_reg   <= '0;
            blend_reg       <= '0;
            active_reg      <= 1'b0;
            loop_reg        <= 1'b0;
            paused_reg      <= 1'b0;
            dvd_reg         <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            iter_reg        <= '0;
            res_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            frame_count_reg <= frame_count_next;
            min_delta_reg   <= min_delta_next;
            op_reg          <= op_next;
            delta_reg       <= delta_next;
            period_reg      <= period_next;
            loop_in_reg     <= loop_in_next;
            pflag_reg       <= pflag_next;
            before_reg      <= before_next;
            ok_reg          <= ok_next;
            elapsed_reg     <= elapsed_next;
            end_time_reg    <= end_time_next;
            cycles_reg      <= cycles_next;
            cur_frame_reg   <= cur_frame_next;
            nxt_frame_reg   <= nxt_frame_next;
            blend_reg       <= blend_next;
            active_reg      <= active_next;
            loop_reg        <= loop_next;
            paused_reg      <= paused_next;
            dvd_reg         <= dvd_next;
            rem_reg         <= rem_next;
            quo_reg         <= quo_next;
            iter_reg        <= iter_next;
            res_reg         <= res_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Checks
    `KAS_ASSERT_NOW(a_elapsed_bound, state_reg == ST_IDLE, elapsed_reg <= {1'b0, end_time_reg}, "elapsed beyond end time while idle")
    `KAS_ASSERT_NOW(a_rem_bound, state_reg == ST_DIV || state_reg == ST_WRAP, rem_reg < end_time_reg, "divider remainder not below divisor")
    `KAS_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready, "new item taken while busy")
    `KAS_ASSERT_NOW(a_start_result, result.valid && result.start_ok, result.active && !result.paused && result.cycle_count == '0 && result.base_frame == '0, "accepted start reports wrong status")

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyframe animation sequencer testbench
// Sends command items through the item channel and checks every status item
// against an untimed model of the playback timer kept inside the bench. A
// short table of directed items comes first, then randomised phases with
// register rewrites, bursty sending and a stalling status receiver.
// ----------------------------------------------------------------------------
module testbench;
    import kas_pkg::*;

    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int ITEM_TARGET            = 1500;
    localparam int HOLD_CYCLES            = 400;
    localparam int WATCHDOG_CYCLES        = 4000;
    localparam int SETTLE_CYCLES          = 100;
    localparam logic [CYC_W-1:0] CYCLE_CAP = '1;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] period;
        logic              loop;
        logic              pflag;
    } anim_cmd_t;

    typedef struct packed {
        logic [FRAME_W-1:0]    base_frame;
        logic [FRAME_W-1:0]    next_frame;
        logic [BLEND_BITS-1:0] blend;
        logic                  active;
        logic                  paused;
        logic                  finished;
        logic [CYC_W-1:0]      cycle_count;
        logic                  start_ok;
        logic                  frame_changed;
    } anim_status_t;

    typedef enum logic {
        STEP_CMD,
        STEP_REG
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        anim_cmd_t             cmd;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  has_want;
        anim_status_t          want;
    } step_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_STRIDE
    } rx_pattern_t;

    logic clk;
    logic rst_n;

    kas_item_if   cmd_bus ();
    kas_result_if status_bus ();
    kas_cfg_if    reg_bus ();

    keyframe_animation_sequencer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (cmd_bus),
        .result (status_bus),
        .cfg    (reg_bus)
    );

    // Timer model: registers and run state as the block holds them
    logic [COUNT_W-1:0]    cfg_frames;
    logic [TIME_W-1:0]     cfg_min_step;
    logic [ELAPSED_W-1:0]  run_time;
    logic [END_W-1:0]      span;
    logic [CYC_W-1:0]      wraps;
    logic [FRAME_W-1:0]    frame_now;
    logic [FRAME_W-1:0]    frame_after;
    logic [BLEND_BITS-1:0] mix;
    logic                  is_running;
    logic                  is_looping;
    logic                  is_held;

    anim_status_t status_due[$];
    step_t        plan[$];
    int           mismatches     = 0;
    int           sent_cmds      = 0;
    int           quiet_cycles   = 0;
    logic         hold_req       = 1'b0;
    logic         flush_out      = 1'b0;

    // Append an expected status item to the tail of the queue
    function automatic void expect_status(input anim_status_t s);
        status_due.insert(status_due.size(), s);
    endfunction

    // Append a row to the directed table
    function automatic void add_step(input step_t s);
        plan.insert(plan.size(), s);
    endfunction

    // Add completed cycles, saturating at the counter's top
    function automatic void bump_wraps(input logic [63:0] add);
        if (add > 64'(CYCLE_CAP - wraps))
            wraps = CYCLE_CAP;
        else
            wraps = wraps + CYC_W'(add);
    endfunction

    // Apply one command to the timer model; return whether it changed anything
    function automatic logic predict_status(input anim_cmd_t c, output anim_status_t s);
        logic [COUNT_W-1:0] n;
        logic [63:0]        t;
        logic [63:0]        num;
        logic [63:0]        q;
        logic [FRAME_W-1:0] prior;
        logic               acted;
        if (cfg_frames == '0)
            n = COUNT_W'(1);
        else if (cfg_frames > COUNT_W'(MAX_FRAMES))
            n = COUNT_W'(MAX_FRAMES);
        else
            n = cfg_frames;
        prior = frame_now;
        acted = 1'b0;
        s     = '0;
        case (c.op)
            OP_ADVANCE:
            begin
                if (is_running && !is_held && c.delta >= cfg_min_step)
                begin
                    acted = 1'b1;
                    t     = 64'(run_time) + 64'(c.delta);
                    if (t > 64'(span) && !is_looping)
                    begin
                        // Play-once overrun: clamp on the last frame and stop
                        run_time    = ELAPSED_W'(span);
                        bump_wraps(64'd1);
                        frame_now   = FRAME_W'(n - 1'b1);
                        frame_after = FRAME_W'(n - 1'b1);
                        mix         = '0;
                        is_running  = 1'b0;
                    end
                    else
                    begin
                        if (t > 64'(span))
                        begin
                            bump_wraps(t / 64'(span));
                            t = t % 64'(span);
                        end
                        run_time    = ELAPSED_W'(t);
                        num         = t * 64'(n - 1'b1);
                        q           = num / 64'(span);
                        frame_now   = FRAME_W'(q);
                        frame_after = FRAME_W'((q + 64'd1) % 64'(n));
                        mix         = BLEND_BITS'(((num % 64'(span)) << BLEND_BITS) / 64'(span));
                    end
                end
            end
            OP_START:
            begin
                if (n > COUNT_W'(1))
                begin
                    acted       = 1'b1;
                    t           = (c.period == '0) ? 64'd1 : 64'(c.period);
                    span        = END_W'(t * 64'(n));
                    run_time    = '0;
                    wraps       = '0;
                    frame_now   = '0;
                    frame_after = FRAME_W'(1);
                    mix         = '0;
                    is_running  = 1'b1;
                    is_looping  = c.loop;
                    is_held     = 1'b0;
                    s.start_ok  = 1'b1;
                end
            end
            OP_PAUSE:
            begin
                if (is_running)
                begin
                    acted   = 1'b1;
                    is_held = c.pflag;
                end
            end
            default: ;
        endcase
        s.base_frame    = frame_now;
        s.next_frame    = frame_after;
        s.blend         = mix;
        s.active        = is_running;
        s.paused        = is_held;
        s.finished      = !is_running && (wraps != '0);
        s.cycle_count   = wraps;
        s.frame_changed = (frame_now != prior);
        return acted;
    endfunction

    function automatic anim_status_t status_of(input int bf, nf, bl, act, pau, fin, cyc, ok,
                                               chg);
        anim_status_t s;
        s.base_frame    = FRAME_W'(bf);
        s.next_frame    = FRAME_W'(nf);
        s.blend         = BLEND_BITS'(bl);
        s.active        = act[0];
        s.paused        = pau[0];
        s.finished      = fin[0];
        s.cycle_count   = CYC_W'(cyc);
        s.start_ok      = ok[0];
        s.frame_changed = chg[0];
        return s;
    endfunction

    function automatic step_t cmd_row(input logic [1:0] op, input logic [TIME_W-1:0] dt,
                                      input logic [TIME_W-1:0] per, input logic lp,
                                      input logic pf);
        step_t s;
        s            = '0;
        s.kind       = STEP_CMD;
        s.cmd.op     = op;
        s.cmd.delta  = dt;
        s.cmd.period = per;
        s.cmd.loop   = lp;
        s.cmd.pflag  = pf;
        return s;
    endfunction

    function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s          = '0;
        s.kind     = STEP_REG;
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic step_t checked(input step_t s, input anim_status_t w);
        step_t r;
        r          = s;
        r.has_want = 1'b1;
        r.want     = w;
        return r;
    endfunction

    // Draw a command, biased towards start-then-advance runs
    function automatic anim_cmd_t random_cmd();
        anim_cmd_t   c;
        int unsigned pick;
        int unsigned top;
        int unsigned lo;
        int unsigned hi;
        c.delta  = TIME_W'($urandom);
        c.period = TIME_W'($urandom);
        c.loop   = 1'($urandom_range(0, 1));
        c.pflag  = 1'($urandom_range(0, 1));
        pick     = $urandom_range(0, 99);
        if (pick < 4)
            c.op = OP_UNUSED;
        else if (pick < 14)
            c.op = OP_PAUSE;
        else if (pick < 24 || (!is_running && pick < 75))
            c.op = OP_START;
        else
            c.op = OP_ADVANCE;
        pick = $urandom_range(0, 9);
        if (c.op == OP_START)
        begin
            if (pick < 7)
                c.period = TIME_W'($urandom_range(1, 32));
            else if (pick == 7)
                c.period = '0;
            else if (pick == 8)
                c.period = '1;
        end
        else if (c.op == OP_ADVANCE)
        begin
            top = (span > END_W'(65535)) ? 65535 : int'(span);
            lo  = (cfg_min_step == '0) ? 0 : int'(cfg_min_step) - 1;
            hi  = (cfg_min_step == '1) ? 65535 : int'(cfg_min_step) + 1;
            if (pick < 4)
                c.delta = TIME_W'($urandom_range(0, 64));
            else if (pick < 6)
                c.delta = TIME_W'($urandom_range(0, top));
            else if (pick == 6)
                c.delta = TIME_W'($urandom_range(lo, hi));
            else if (pick == 7)
                c.delta = '1;
        end
        return c;
    endfunction

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Offer one item, hold it until taken, then record its expected status
    task automatic offer_cmd(input anim_cmd_t c, input logic has_want,
                             input anim_status_t want);
        anim_status_t guess;
        @(negedge clk);
        cmd_bus.valid        = 1'b1;
        cmd_bus.operation    = c.op;
        cmd_bus.delta_time   = c.delta;
        cmd_bus.frame_period = c.period;
        cmd_bus.loop_mode    = c.loop;
        cmd_bus.pause_flag   = c.pflag;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        void'(predict_status(c, guess));
        sent_cmds++;
        expect_status(has_want ? want : guess);
    endtask

    task automatic idle_sender(input int gap);
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
    endtask

    // Drop valid and wait until every expected status has come back
    task automatic settle();
        @(negedge clk);
        cmd_bus.valid = 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        reg_bus.valid = 1'b1;
        reg_bus.index = idx;
        reg_bus.data  = data;
        do
            @(posedge clk);
        while (!reg_bus.ready);
        if (idx == REG_FRAME_COUNT)
            cfg_frames = data[COUNT_W-1:0];
        else
            cfg_min_step = data[TIME_W-1:0];
        @(negedge clk);
        reg_bus.valid = 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Status receiver: stall pattern of its own plus one long hold-off
    initial
    begin
        rx_pattern_t rx_mode;
        int          mode_left;
        int          hold_left;
        status_bus.ready = 1'b0;
        rx_mode          = RX_OPEN;
        mode_left        = 0;
        hold_left        = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_pattern_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (flush_out)
                status_bus.ready = 1'b1;
            else if (hold_left != 0)
            begin
                status_bus.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   status_bus.ready = 1'b1;
                    RX_MOSTLY: status_bus.ready = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: status_bus.ready = ($urandom_range(0, 3) == 0);
                    default:   status_bus.ready = (mode_left % 8 == 0);
                endcase
            end
        end
    end

    // Compare each taken status item with the oldest expectation
    initial
    begin
        anim_status_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && status_bus.valid && status_bus.ready)
            begin
                if (status_due.size() == 0)
                begin
                    mismatches++;
                    $error("status item with no command outstanding");
                end
                else
                begin
                    want = status_due.pop_front();
                    match_field("base_frame", 32'(want.base_frame),
                                32'(status_bus.base_frame));
                    match_field("next_frame", 32'(want.next_frame),
                                32'(status_bus.next_frame));
                    match_field("blend", 32'(want.blend), 32'(status_bus.blend));
                    match_field("active", 32'(want.active), 32'(status_bus.active));
                    match_field("paused", 32'(want.paused), 32'(status_bus.paused));
                    match_field("finished", 32'(want.finished), 32'(status_bus.finished));
                    match_field("cycle_count", 32'(want.cycle_count),
                                32'(status_bus.cycle_count));
                    match_field("start_ok", 32'(want.start_ok), 32'(status_bus.start_ok));
                    match_field("frame_changed", 32'(want.frame_changed),
                                32'(status_bus.frame_changed));
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((cmd_bus.valid && cmd_bus.ready) || (status_bus.valid && status_bus.ready) ||
                (reg_bus.valid && reg_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        int                    phase;
        int                    burst;
        int                    batch;
        logic                  no_gaps;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] word;

        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.operation    = '0;
        cmd_bus.delta_time   = '0;
        cmd_bus.frame_period = '0;
        cmd_bus.loop_mode    = 1'b0;
        cmd_bus.pause_flag   = 1'b0;
        reg_bus.valid        = 1'b0;
        reg_bus.index        = '0;
        reg_bus.data         = '0;

        // Model starts from the block's reset state
        cfg_frames   = COUNT_W'(1);
        cfg_min_step = TIME_W'(7);
        run_time     = '0;
        span         = '0;
        wraps        = '0;
        frame_now    = '0;
        frame_after  = '0;
        mix          = '0;
        is_running   = 1'b0;
        is_looping   = 1'b0;
        is_held      = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Out of reset with a single frame: nothing can run
        add_step(checked(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0001, 1'b0, 1'b0),
                         status_of(0, 0, 0, 0, 0, 0, 0, 0, 0)));
        add_step(checked(cmd_row(OP_START, 16'h0000, 16'd100, 1'b1, 1'b0),
                         status_of(0, 0, 0, 0, 0, 0, 0, 0, 0)));
        add_step(checked(cmd_row(OP_PAUSE, 16'h0000, 16'h0000, 1'b0, 1'b1),
                         status_of(0, 0, 0, 0, 0, 0, 0, 0, 0)));
        add_step(checked(cmd_row(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1),
                         status_of(0, 0, 0, 0, 0, 0, 0, 0, 0)));
        // Four frames, zero period, step through to the end and past it
        add_step(reg_row(REG_FRAME_COUNT, 16'd4));
        add_step(reg_row(REG_MIN_DELTA, 16'd0));
        add_step(checked(cmd_row(OP_START, 16'hFFFF, 16'h0000, 1'b0, 1'b0),
                         status_of(0, 1, 0, 1, 0, 0, 0, 1, 0)));
        add_step(cmd_row(OP_ADVANCE, 16'd0, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'd3, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'd1, 16'h0000, 1'b0, 1'b0));
        add_step(checked(cmd_row(OP_ADVANCE, 16'd1, 16'h0000, 1'b0, 1'b0),
                         status_of(3, 3, 0, 0, 0, 1, 1, 0, 0)));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_PAUSE, 16'h0000, 16'h0000, 1'b0, 1'b1));
        // Looping run with the longest period, paused and resumed
        add_step(checked(cmd_row(OP_START, 16'h0000, 16'hFFFF, 1'b1, 1'b0),
                         status_of(0, 1, 0, 1, 0, 0, 0, 1, 1)));
        add_step(cmd_row(OP_PAUSE, 16'h0000, 16'h0000, 1'b0, 1'b1));
        add_step(cmd_row(OP_ADVANCE, 16'd1000, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_PAUSE, 16'h0000, 16'h0000, 1'b0, 1'b0));
        add_step(reg_row(REG_MIN_DELTA, 16'hFFFF));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFE, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        // Count above the maximum saturates; longest end time
        add_step(reg_row(REG_FRAME_COUNT, 16'hFFFF));
        add_step(reg_row(REG_MIN_DELTA, 16'd0));
        add_step(cmd_row(OP_START, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        // Two frames, shortest loop: one wrap, then the cycle count saturates
        add_step(reg_row(REG_FRAME_COUNT, 16'd2));
        add_step(cmd_row(OP_START, 16'h0000, 16'd1, 1'b1, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'd3, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        add_step(cmd_row(OP_ADVANCE, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        // A zero count acts as one frame: start refused
        add_step(reg_row(REG_FRAME_COUNT, 16'hFE00));
        add_step(cmd_row(OP_START, 16'h0000, 16'd5, 1'b1, 1'b0));

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end
            else
                offer_cmd(plan[i].cmd, plan[i].has_want, plan[i].want);
        end

        // Random phases: rewrite both registers, then a bursty batch of items
        phase = 0;
        while (sent_cmds < ITEM_TARGET)
        begin
            settle();
            pick = $urandom_range(0, 9);
            word = CFG_DATA_W'($urandom);
            if (pick < 5)
                word[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 8));
            else if (pick < 7)
                word[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 256));
            else if (pick == 7)
                word[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 1));
            else if (pick == 8)
                word[COUNT_W-1:0] = COUNT_W'($urandom_range(257, 511));
            else
                word[COUNT_W-1:0] = COUNT_W'(256);
            write_reg(REG_FRAME_COUNT, word);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                word = CFG_DATA_W'($urandom_range(0, 16));
            else if (pick == 5)
                word = '0;
            else if (pick == 6)
                word = '1;
            else
                word = CFG_DATA_W'($urandom);
            write_reg(REG_MIN_DELTA, word);

            // Hold the receiver off once so the block backs up
            if (phase == 1)
                hold_req = 1'b1;
            batch   = $urandom_range(20, 80);
            no_gaps = ($urandom_range(0, 3) == 0);
            burst   = $urandom_range(1, 24);
            repeat (batch)
            begin
                if (!no_gaps && burst == 0)
                begin
                    idle_sender($urandom_range(1, 12));
                    burst = $urandom_range(1, 24);
                end
                offer_cmd(random_cmd(), 1'b0, '0);
                if (burst != 0)
                    burst--;
            end
            phase++;
        end

        // Drain, then watch a while longer for stray status items
        settle();
        flush_out = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
